/* rtl/core/bright_pixel_bounding_box_top_assert.svh */
// Assertion macros for the bright pixel bounding box block.
// Used by bright_pixel_bounding_box_top; expects a clk and rst in scope.
`ifndef BRIGHT_PIXEL_BOUNDING_BOX_TOP_ASSERT_SVH
`define BRIGHT_PIXEL_BOUNDING_BOX_TOP_ASSERT_SVH

// same-cycle implication
`define BPBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bpbb_pkg.sv */
// Package for the bright pixel bounding box block: widths, register codes, helpers.
// No dependencies.
package bpbb_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = 13;
  localparam int POS_W         = 12;
  localparam int PIX_W         = 8;
  localparam int MARGIN_W      = 12;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;

  localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd480;
  localparam logic [PIX_W-1:0]    RST_THRESHOLD    = 8'd90;
  localparam logic [MARGIN_W-1:0] RST_MARGIN       = 12'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2,
    REG_MARGIN       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             any;
    logic [POS_W-1:0] lo_col;
    logic [POS_W-1:0] hi_col;
    logic [POS_W-1:0] lo_row;
    logic [POS_W-1:0] hi_row;
  } extent_t;

  typedef struct packed {
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } edge_t;

  // clamp a size register to 1..MAX_DIMENSION
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    return r;
  endfunction

  // low edge floored at zero, high edge capped at size-1, low never above high
  function automatic edge_t edge_pair(input logic [POS_W-1:0] lo_ext,
                                      input logic [POS_W-1:0] hi_ext,
                                      input logic [DIM_W-1:0] size,
                                      input logic [MARGIN_W-1:0] margin);
    edge_t            e;
    logic [DIM_W-1:0] b;
    logic [DIM_W-1:0] cap;
    cap = size - DIM_W'(1);
    b   = {1'b0, hi_ext} + {1'b0, margin};
    if (b >= size) b = cap;
    e.hi = b[POS_W-1:0];
    e.lo = (lo_ext > margin) ? (lo_ext - margin) : '0;
    if (e.lo > e.hi) e.lo = e.hi;
    return e;
  endfunction

endpackage

/* rtl/core/bpbb_ifs.sv */
// Channel interfaces for the bright pixel bounding box block.
// Depends on bpbb_pkg.
interface bpbb_pix_if import bpbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface bpbb_box_if import bpbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] box_x;
  logic [POS_W-1:0] box_y;
  logic [POS_W-1:0] box_width;
  logic [POS_W-1:0] box_height;
  modport source (output valid, output box_x, output box_y, output box_width,
                  output box_height, input ready);
  modport sink (input valid, input box_x, input box_y, input box_width,
                input box_height, output ready);
endinterface

interface bpbb_cfg_if import bpbb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/bpbb_track.sv */
// Raster position counters and bright-pixel extent tracking for one frame.
// Depends on bpbb_pkg.
module bpbb_track import bpbb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [PIX_W-1:0] pixel_value,
  input  logic [PIX_W-1:0] threshold,
  input  logic [DIM_W-1:0] cols,
  input  logic [DIM_W-1:0] rows,
  output logic             last,
  output extent_t          ext_next
);

  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  extent_t          ext;
  logic             bright;
  logic             row_end;

  assign bright  = pixel_value > threshold;
  assign row_end = !(({1'b0, col} + DIM_W'(1)) < cols);
  assign last    = row_end && !(({1'b0, row} + DIM_W'(1)) < rows);

  always_comb begin
    ext_next = ext;
    if (bright) begin
      if (!ext.any || col < ext.lo_col) ext_next.lo_col = col;
      if (!ext.any || col > ext.hi_col) ext_next.hi_col = col;
      if (!ext.any || row < ext.lo_row) ext_next.lo_row = row;
      if (!ext.any || row > ext.hi_row) ext_next.hi_row = row;
      ext_next.any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (go && last)) begin
      col        <= '0;
      row        <= '0;
      ext.any    <= 1'b0;
      ext.lo_col <= '1;
      ext.hi_col <= '0;
      ext.lo_row <= '1;
      ext.hi_row <= '0;
    end else if (go) begin
      ext <= ext_next;
      if (row_end) begin
        col <= '0;
        row <= row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

endmodule

/* rtl/core/bright_pixel_bounding_box_top.sv */
// A frame's last pixel passes the input stage, then the summary and box registers.
// Throughput: one pixel per cycle; the input stage, the frame summary register and
// the box register each hold one request, so a stalled box only blocks pixels once
// the summary register is also full. Config requests are taken every cycle.
// Reset (rst, synchronous): pipeline empty, counters and extents cleared,
// registers at 640 x 480, threshold 90, margin 60.
`include "bright_pixel_bounding_box_top_assert.svh"

module bright_pixel_bounding_box_top import bpbb_pkg::*; (
  input logic       clk,
  input logic       rst,
  bpbb_pix_if.sink  pixel,
  bpbb_box_if.source box,
  bpbb_cfg_if.sink  cfg
);

  logic [DIM_W-1:0]    frame_width;
  logic [DIM_W-1:0]    frame_height;
  logic [PIX_W-1:0]    bright_threshold;
  logic [MARGIN_W-1:0] edge_margin;
  logic [DIM_W-1:0]    cols;
  logic [DIM_W-1:0]    rows;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic             sum_valid;
  extent_t          sum;
  logic             out_free;
  logic             sum_free;
  logic             s1_go;
  logic             last;
  extent_t          ext_next;
  edge_t            xe;
  edge_t            ye;

  assign cols      = eff_size(frame_width);
  assign rows      = eff_size(frame_height);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= RST_FRAME_WIDTH;
      frame_height     <= RST_FRAME_HEIGHT;
      bright_threshold <= RST_THRESHOLD;
      edge_margin      <= RST_MARGIN;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_FRAME_WIDTH:  frame_width      <= cfg.data;
        REG_FRAME_HEIGHT: frame_height     <= cfg.data;
        REG_THRESHOLD:    bright_threshold <= cfg.data[PIX_W-1:0];
        REG_MARGIN:       edge_margin      <= cfg.data[MARGIN_W-1:0];
        default:          ;
      endcase
    end
  end

  assign out_free    = !box.valid || box.ready;
  assign sum_free    = !sum_valid || out_free;
  assign s1_go       = s1_valid && sum_free;
  assign pixel.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.valid && pixel.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      s1_pix <= pixel.pixel_value;
    end
  end

  bpbb_track u_track (
    .clk         (clk),
    .rst         (rst),
    .go          (s1_go),
    .pixel_value (s1_pix),
    .threshold   (bright_threshold),
    .cols        (cols),
    .rows        (rows),
    .last        (last),
    .ext_next    (ext_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (s1_go && last) begin
      sum_valid <= 1'b1;
    end else if (out_free) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && last) begin
      sum <= ext_next;
    end
  end

  always_comb begin
    if (sum.any) begin
      xe = edge_pair(sum.lo_col, sum.hi_col, cols, edge_margin);
      ye = edge_pair(sum.lo_row, sum.hi_row, rows, edge_margin);
    end else begin
      xe.lo = '0;
      xe.hi = POS_W'(cols - DIM_W'(1));
      ye.lo = '0;
      ye.hi = POS_W'(rows - DIM_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box.valid <= 1'b0;
    end else if (out_free) begin
      box.valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && sum_valid) begin
      box.box_x      <= xe.lo;
      box.box_y      <= ye.lo;
      box.box_width  <= xe.hi - xe.lo;
      box.box_height <= ye.hi - ye.lo;
    end
  end

  `BPBB_ASSERT_NOW(a_box_in_cols, box.valid,
    ({1'b0, box.box_x} + {1'b0, box.box_width}) < cols, "box exceeds frame width")
  `BPBB_ASSERT_NOW(a_box_in_rows, box.valid,
    ({1'b0, box.box_y} + {1'b0, box.box_height}) < rows, "box exceeds frame height")
  `BPBB_ASSERT_NOW(a_s1_stall_cause, s1_valid && !s1_go,
    sum_valid && !out_free, "pixel stage stalled without a blocked summary")
  `BPBB_ASSERT_NEXT(a_sum_held, sum_valid && !out_free, sum_valid,
    "blocked summary was dropped")

endmodule
